// ===== rtl/core/trs_pkg.sv =====
package trs_pkg;

  localparam int unsigned TransW = 32;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned ProdW  = 2 * QuatW;
  localparam int unsigned TermW  = ProdW + 2;
  localparam int unsigned WideW  = TermW + ScaleW;
  localparam int unsigned FracDrop = 20;
  localparam int unsigned OutW   = 32;
  localparam int unsigned NumEntries = 9;

  localparam logic signed [TermW-1:0] OneQ28 = TermW'(64'sd268435456);

  typedef struct packed {
    logic signed [TransW-1:0] translate_x;
    logic signed [TransW-1:0] translate_y;
    logic signed [TransW-1:0] translate_z;
    logic signed [QuatW-1:0]  quat_x;
    logic signed [QuatW-1:0]  quat_y;
    logic signed [QuatW-1:0]  quat_z;
    logic signed [QuatW-1:0]  quat_w;
    logic signed [ScaleW-1:0] scale_x;
    logic signed [ScaleW-1:0] scale_y;
    logic signed [ScaleW-1:0] scale_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] col0_x;
    logic signed [OutW-1:0] col0_y;
    logic signed [OutW-1:0] col0_z;
    logic signed [OutW-1:0] col1_x;
    logic signed [OutW-1:0] col1_y;
    logic signed [OutW-1:0] col1_z;
    logic signed [OutW-1:0] col2_x;
    logic signed [OutW-1:0] col2_y;
    logic signed [OutW-1:0] col2_z;
    logic signed [OutW-1:0] col3_x;
    logic signed [OutW-1:0] col3_y;
    logic signed [OutW-1:0] col3_z;
  } out_item_t;

  typedef struct packed {
    logic signed [TransW-1:0] x;
    logic signed [TransW-1:0] y;
    logic signed [TransW-1:0] z;
  } trans_t;

  typedef struct packed {
    logic signed [ScaleW-1:0] x;
    logic signed [ScaleW-1:0] y;
    logic signed [ScaleW-1:0] z;
  } scale_t;

endpackage

// ===== rtl/core/trs_stream_if.sv =====
interface trs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/trs_matrix_from_quaternion_core.sv =====
// Each accepted input item passes through the four register stages (products, sums, scaling,
// truncation) to its result item on the output. Throughput: one item per cycle while the output
// is ready; the stages each advance on their own, so a stalled output fills bubbles first.
// Reset: rst_ni clears the valid bit of every stage asynchronously; the data
// registers are not reset.
module trs_matrix_from_quaternion_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  trs_stream_if.sink   in_i,
  trs_stream_if.source out_o
);

  localparam int unsigned ProdW  = trs_pkg::ProdW;
  localparam int unsigned TermW  = trs_pkg::TermW;
  localparam int unsigned WideW  = trs_pkg::WideW;
  localparam int unsigned OutW   = trs_pkg::OutW;
  localparam int unsigned NumE   = trs_pkg::NumEntries;
  localparam int unsigned Drop   = trs_pkg::FracDrop;

  trs_pkg::in_item_t in_item;
  assign in_item = in_i.data;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: the nine single products of quaternion components.
  logic signed [ProdW-1:0] xx_q, xy_q, xz_q, yy_q, yz_q, zz_q, wx_q, wy_q, wz_q;
  trs_pkg::scale_t s1_scale_q;
  trs_pkg::trans_t s1_trans_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      xx_q <= $signed(in_item.quat_x) * $signed(in_item.quat_x);
      xy_q <= $signed(in_item.quat_x) * $signed(in_item.quat_y);
      xz_q <= $signed(in_item.quat_x) * $signed(in_item.quat_z);
      yy_q <= $signed(in_item.quat_y) * $signed(in_item.quat_y);
      yz_q <= $signed(in_item.quat_y) * $signed(in_item.quat_z);
      zz_q <= $signed(in_item.quat_z) * $signed(in_item.quat_z);
      wx_q <= $signed(in_item.quat_w) * $signed(in_item.quat_x);
      wy_q <= $signed(in_item.quat_w) * $signed(in_item.quat_y);
      wz_q <= $signed(in_item.quat_w) * $signed(in_item.quat_z);
      s1_scale_q <= '{x: in_item.scale_x, y: in_item.scale_y, z: in_item.scale_z};
      s1_trans_q <= '{x: in_item.translate_x, y: in_item.translate_y,
                      z: in_item.translate_z};
    end
  end

  // Stage 2: doubled products combined into the nine rotation terms in Q.28.
  function automatic logic signed [TermW-1:0] dbl(input logic signed [ProdW-1:0] p);
    dbl = $signed({p[ProdW-1], p, 1'b0});
  endfunction

  logic signed [TermW-1:0] term_d [NumE];
  logic signed [TermW-1:0] term_q [NumE];
  trs_pkg::scale_t s2_scale_q;
  trs_pkg::trans_t s2_trans_q;

  always_comb begin
    term_d[0] = trs_pkg::OneQ28 - (dbl(yy_q) + dbl(zz_q));
    term_d[1] = dbl(xy_q) + dbl(wz_q);
    term_d[2] = dbl(xz_q) - dbl(wy_q);
    term_d[3] = dbl(xy_q) - dbl(wz_q);
    term_d[4] = trs_pkg::OneQ28 - (dbl(xx_q) + dbl(zz_q));
    term_d[5] = dbl(yz_q) + dbl(wx_q);
    term_d[6] = dbl(xz_q) + dbl(wy_q);
    term_d[7] = dbl(yz_q) - dbl(wx_q);
    term_d[8] = trs_pkg::OneQ28 - (dbl(xx_q) + dbl(yy_q));
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      term_q     <= term_d;
      s2_scale_q <= s1_scale_q;
      s2_trans_q <= s1_trans_q;
    end
  end

  // Stage 3: each term times the scale of its column, exact in Q.36.
  logic signed [WideW-1:0] wide_q [NumE];
  trs_pkg::trans_t s3_trans_q;

  for (genvar k = 0; k < NumE; k++) begin : g_scale
    localparam int unsigned Col = k / 3;
    logic signed [trs_pkg::ScaleW-1:0] sc;
    assign sc = (Col == 0) ? s2_scale_q.x : ((Col == 1) ? s2_scale_q.y : s2_scale_q.z);
    always_ff @(posedge clk_i) begin
      if (en3) begin
        wide_q[k] <= WideW'(term_q[k]) * WideW'(sc);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) s3_trans_q <= s2_trans_q;
  end

  // Stage 4: drop the low fraction bits, flooring. The remaining value always fits
  // in the 32-bit range, so saturation reduces to sign extension.
  logic signed [OutW-1:0] ent_q [NumE];
  trs_pkg::trans_t s4_trans_q;

  for (genvar k = 0; k < NumE; k++) begin : g_trunc
    always_ff @(posedge clk_i) begin
      if (en4) begin
        ent_q[k] <= OutW'($signed(wide_q[k][WideW-1:Drop]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) s4_trans_q <= s3_trans_q;
  end

  assign out_o.valid = v4_q;
  assign out_o.data  = '{
    col0_x: ent_q[0], col0_y: ent_q[1], col0_z: ent_q[2],
    col1_x: ent_q[3], col1_y: ent_q[4], col1_z: ent_q[5],
    col2_x: ent_q[6], col2_y: ent_q[7], col2_z: ent_q[8],
    col3_x: s4_trans_q.x, col3_y: s4_trans_q.y, col3_z: s4_trans_q.z
  };

endmodule

// ===== tb/trs_matrix_from_quaternion_core_tb.sv =====
`timescale 1ns / 1ps

module trs_matrix_from_quaternion_core_tb;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ItemsPerPhase = 333;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  trs_stream_if #(.T(trs_pkg::in_item_t))  trs_in ();
  trs_stream_if #(.T(trs_pkg::out_item_t)) matrix_out ();

  trs_matrix_from_quaternion_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (trs_in),
    .out_o (matrix_out)
  );

  trs_pkg::in_item_t  pending_trs[$];
  trs_pkg::out_item_t expected_matrices[$];
  trs_pkg::out_item_t oldest_matrix;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  // A doubled-product term in Q.28 times a Q8.8 scale, floored to Q16.16 and clamped.
  function automatic logic [trs_pkg::OutW-1:0] scale_to_q16(longint term, longint s);
    longint prod;
    longint q;
    prod = term * s;
    q = prod >>> trs_pkg::FracDrop;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[trs_pkg::OutW-1:0];
  endfunction

  function automatic trs_pkg::out_item_t compose_trs_matrix(trs_pkg::in_item_t a);
    trs_pkg::out_item_t m;
    longint x, y, z, w, sx, sy, sz, one;
    longint xx, xy, xz, yy, yz, zz, wx, wy, wz;
    x = $signed(a.quat_x);
    y = $signed(a.quat_y);
    z = $signed(a.quat_z);
    w = $signed(a.quat_w);
    sx = $signed(a.scale_x);
    sy = $signed(a.scale_y);
    sz = $signed(a.scale_z);
    one = 64'sd1 <<< 28;
    xx = 2 * x * x;
    xy = 2 * x * y;
    xz = 2 * x * z;
    yy = 2 * y * y;
    yz = 2 * y * z;
    zz = 2 * z * z;
    wx = 2 * w * x;
    wy = 2 * w * y;
    wz = 2 * w * z;
    m.col0_x = scale_to_q16(one - (yy + zz), sx);
    m.col0_y = scale_to_q16(xy + wz, sx);
    m.col0_z = scale_to_q16(xz - wy, sx);
    m.col1_x = scale_to_q16(xy - wz, sy);
    m.col1_y = scale_to_q16(one - (xx + zz), sy);
    m.col1_z = scale_to_q16(yz + wx, sy);
    m.col2_x = scale_to_q16(xz + wy, sz);
    m.col2_y = scale_to_q16(yz - wx, sz);
    m.col2_z = scale_to_q16(one - (xx + yy), sz);
    m.col3_x = a.translate_x;
    m.col3_y = a.translate_y;
    m.col3_z = a.translate_z;
    return m;
  endfunction

  function automatic logic [15:0] pick16(int unsigned kind);
    logic [15:0] corners[8];
    corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000, 16'h0100,
                16'h0001};
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(32767) - 16384);
      2: return 16'($urandom_range(2047) - 1024);
      default: return corners[$urandom_range(7)];
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    logic [31:0] corners[4];
    corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    if ($urandom_range(9) == 0) return corners[$urandom_range(3)];
    return $urandom;
  endfunction

  // Equal shares: raw bits, corners, components in [-1, 1) or small with small scales.
  function automatic trs_pkg::in_item_t random_trs();
    trs_pkg::in_item_t t;
    int unsigned qk;
    int unsigned sk;
    qk = $urandom_range(3);
    sk = (qk == 1) ? 2 : qk;
    t.translate_x = pick32();
    t.translate_y = pick32();
    t.translate_z = pick32();
    t.quat_x = pick16(qk);
    t.quat_y = pick16(qk);
    t.quat_z = pick16(qk);
    t.quat_w = pick16(qk);
    t.scale_x = pick16(sk);
    t.scale_y = pick16(sk);
    t.scale_z = pick16(sk);
    return t;
  endfunction

  task automatic push_trs(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                          logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                          logic [15:0] qw, logic [15:0] sx, logic [15:0] sy,
                          logic [15:0] sz);
    trs_pkg::in_item_t t;
    t = '{tx, ty, tz, qx, qy, qz, qw, sx, sy, sz};
    pending_trs.push_back(t);
  endtask

  task automatic wait_drained();
    while (pending_trs.size() != 0 || trs_in.valid || expected_matrices.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    repeat (ItemsPerPhase) pending_trs.push_back(random_trs());
    wait_drained();
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trs_in.valid <= 1'b0;
    end else begin
      if (trs_in.valid && trs_in.ready) begin
        expected_matrices.push_back(compose_trs_matrix(trs_in.data));
      end
      if (!trs_in.valid || trs_in.ready) begin
        if (pending_trs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          trs_in.valid <= 1'b1;
          trs_in.data <= pending_trs.pop_front();
        end else begin
          trs_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_out.ready <= 1'b0;
    end else begin
      if (matrix_out.valid && matrix_out.ready) begin
        if (expected_matrices.size() == 0) begin
          $error("result item arrived with no input item outstanding");
          mismatch_count++;
        end else begin
          oldest_matrix = expected_matrices.pop_front();
          check_field("col0_x", oldest_matrix.col0_x, matrix_out.data.col0_x);
          check_field("col0_y", oldest_matrix.col0_y, matrix_out.data.col0_y);
          check_field("col0_z", oldest_matrix.col0_z, matrix_out.data.col0_z);
          check_field("col1_x", oldest_matrix.col1_x, matrix_out.data.col1_x);
          check_field("col1_y", oldest_matrix.col1_y, matrix_out.data.col1_y);
          check_field("col1_z", oldest_matrix.col1_z, matrix_out.data.col1_z);
          check_field("col2_x", oldest_matrix.col2_x, matrix_out.data.col2_x);
          check_field("col2_y", oldest_matrix.col2_y, matrix_out.data.col2_y);
          check_field("col2_z", oldest_matrix.col2_z, matrix_out.data.col2_z);
          check_field("col3_x", oldest_matrix.col3_x, matrix_out.data.col3_x);
          check_field("col3_y", oldest_matrix.col3_y, matrix_out.data.col3_y);
          check_field("col3_z", oldest_matrix.col3_z, matrix_out.data.col3_z);
        end
      end
      matrix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((trs_in.valid && trs_in.ready) || (matrix_out.valid && matrix_out.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    trs_in.valid = 1'b0;
    trs_in.data = '0;
    matrix_out.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    quiet_cycles = 0;

    // Identity, pure scale, zero scale and the translation extremes.
    push_trs(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0100, 16'h0100, 16'h0100);
    push_trs(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
             16'h0, 16'h0, 16'h0, 16'h4000, 16'h0200, 16'hFF00, 16'h0080);
    push_trs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
             16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    push_trs(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
             16'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0100);
    // Quarter turns about each axis.
    push_trs(32'h0001_0000, 32'h0, 32'h0, 16'h2D41, 16'h0, 16'h0, 16'h2D41,
             16'h0100, 16'h0100, 16'h0100);
    push_trs(32'h0, 32'h0001_0000, 32'h0, 16'h0, 16'h2D41, 16'h0, 16'h2D41,
             16'h0100, 16'h0100, 16'h0100);
    push_trs(32'h0, 32'h0, 32'h0001_0000, 16'h0, 16'h0, 16'h2D41, 16'h2D41,
             16'h0100, 16'h0100, 16'h0100);
    // Half turn and a negated unit quaternion.
    push_trs(32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0100);
    push_trs(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'hC000, 16'h0100, 16'h0100, 16'h0100);
    // Non-unit quaternions with components at the largest and the most negative values.
    push_trs(32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_trs(32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
             16'h8000, 16'h8000, 16'h8000);
    push_trs(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
             16'h7FFF, 16'h8000, 16'h7FFF);
    push_trs(32'h0, 32'h0, 32'h0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
             16'h8000, 16'h7FFF, 16'h8000);
    push_trs(32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h0, 16'h0, 16'h8000,
             16'h8000, 16'h8000, 16'h8000);
    push_trs(32'h0, 32'h0, 32'h0, 16'h0, 16'h8000, 16'h8000, 16'h0,
             16'h7FFF, 16'h7FFF, 16'h7FFF);
    // Smallest step in every field, all ones, and a mix of fractional values.
    push_trs(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 16'h0001, 16'h0001, 16'h0001,
             16'h0001, 16'h0001, 16'h0001, 16'h0001);
    push_trs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_trs(32'h0, 32'h0, 32'h0, 16'h1000, 16'h2000, 16'h3000, 16'h0800,
             16'hFE80, 16'h0180, 16'h0040);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    run_phase(0, 0);
    run_phase(84, 0);
    run_phase(0, 84);
    run_phase(36, 36);

    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0 && expected_matrices.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
